@@ rtl/drrip_pkg.sv @@
package drrip_pkg;

  localparam int NUM_SETS = 2048;
  localparam int NUM_WAYS = 16;
  localparam int LEADERS  = 64;
  localparam int SET_W    = 11;
  localparam int WAY_W    = 4;
  localparam int ADDR_W   = 64;
  localparam int PSEL_W   = 10;
  localparam int CNT_W    = 2;
  localparam int LFSR_W   = 16;

  localparam logic [1:0]        RRPV_MAX  = 2'd3;
  localparam logic [1:0]        RRPV_NEAR = 2'd2;
  localparam logic [PSEL_W-1:0] PSEL_MID  = 10'd512;
  localparam logic [PSEL_W-1:0] PSEL_TOP  = 10'd1023;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_INIT = 16'd1;
  localparam logic [CNT_W-1:0]  CNT_TOP   = 2'd3;
  localparam logic [CNT_W-1:0]  THR_INIT  = 2'd2;

  // command codes
  localparam logic [1:0] CMD_VICTIM = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_BEAT   = 2'd2;

  typedef logic [NUM_WAYS-1:0][1:0] row_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prev_addr;
    logic [ADDR_W-1:0] prev_stride;
    logic [CNT_W-1:0]  cnt;
  } set_rec_t;

  // ageing / search unit results
  typedef struct packed {
    logic             inv_any;
    logic [WAY_W-1:0] inv_way;
    logic             max_any;
    logic [WAY_W-1:0] max_way;
    row_t             aged;
  } age_res_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOOK, S_AGE, S_U1, S_U2, S_HB_RD, S_HB_WR, S_HB_LAST, S_DONE
  } state_t;

  // Galois LFSR, one shift right
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] l);
    logic [LFSR_W-1:0] n;
    n = l >> 1;
    if (l[0]) n = n ^ LFSR_TAPS;
    return n;
  endfunction

endpackage

@@ rtl/drrip_age_unit.sv @@
// Shared row unit: first invalid way, first way at max RRPV, row aged by one
module drrip_age_unit (
  input  drrip_pkg::row_t               row,
  input  logic [drrip_pkg::NUM_WAYS-1:0] valid_mask,
  output drrip_pkg::age_res_t           res
);

  always_comb begin
    res = '0;
    for (int w = drrip_pkg::NUM_WAYS - 1; w >= 0; w--) begin
      if (!valid_mask[w]) begin
        res.inv_any = 1'b1;
        res.inv_way = drrip_pkg::WAY_W'(w);
      end
      if (row[w] == drrip_pkg::RRPV_MAX) begin
        res.max_any = 1'b1;
        res.max_way = drrip_pkg::WAY_W'(w);
      end
      res.aged[w] = row[w] + 2'd1;
    end
  end

endmodule

@@ rtl/drrip_streaming_replacement.sv @@
// DRRIP replacement with per-set stride streaming detection. After reset the
// block runs a clearing pass over its set memories and takes no item
// meanwhile. A victim query finishes after the lookup step when some way is
// invalid, and otherwise goes on from the row read through up to three ageing
// passes of the shared row unit plus the pass that finds the way at max RRPV.
// An update runs set read, 64-bit stride subtract, compare and write back, then
// result load, and a heartbeat tick sweeps every set through one memory port,
// reading and then writing each set. One item is in flight at a time; a finished
// result sits in the output register while the next item is taken, and a result
// that cannot load because the receiver holds off keeps the block busy until it
// does.
module drrip_streaming_replacement (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,     // stream_threshold
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,        // set_index, way_index, phys_addr, valid_mask, zero pad
  input  logic [2:0]  in_tuser,        // cmd, is_hit
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,       // victim_way, psel_value, zero pad
  output logic        out_tuser        // set_streaming
);

  localparam int SW = drrip_pkg::SET_W;
  localparam int WW = drrip_pkg::WAY_W;
  localparam int AW = drrip_pkg::ADDR_W;

  drrip_pkg::state_t state_r, state_nxt;

  // memories
  drrip_pkg::row_t     rrpv_mem [drrip_pkg::NUM_SETS];
  drrip_pkg::set_rec_t set_mem  [drrip_pkg::NUM_SETS];
  drrip_pkg::row_t     rrpv_q;
  drrip_pkg::set_rec_t set_q;
  logic [SW-1:0]       rd_addr;
  logic                rrpv_we, set_we;
  logic [SW-1:0]       wr_addr;
  drrip_pkg::row_t     rrpv_wd;
  drrip_pkg::set_rec_t set_wd;

  // item registers
  logic [1:0]    cmd_r;
  logic [SW-1:0] set_r;
  logic [WW-1:0] way_r;
  logic [AW-1:0] addr_r;
  logic          hit_r;
  logic [15:0]   vmask_r;

  // working registers
  logic [SW-1:0]                   idx_r, idx_nxt;
  drrip_pkg::row_t                 row_r, row_nxt;
  drrip_pkg::set_rec_t             rec_r, rec_nxt;
  logic [AW-1:0]                   stride_r, stride_nxt;
  logic [drrip_pkg::PSEL_W-1:0]    psel_r, psel_nxt;
  logic [drrip_pkg::LFSR_W-1:0]    lfsr_r, lfsr_nxt;
  logic [1:0]                      thr_r;
  logic [WW-1:0]                   vic_r, vic_nxt;
  logic                            strm_r, strm_nxt;

  // output register
  logic          out_valid_r;
  logic [WW-1:0] out_vic_r;
  logic [drrip_pkg::PSEL_W-1:0] out_psel_r;
  logic          out_strm_r;
  logic          out_load;

  logic in_xfer;
  drrip_pkg::age_res_t age_res;

  assign in_tready = (state_r == drrip_pkg::S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == drrip_pkg::S_DONE) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_psel_r, out_vic_r};
  assign out_tuser  = out_strm_r;

  drrip_age_unit u_age (
    .row       (row_r),
    .valid_mask(vmask_r),
    .res       (age_res)
  );

  // read address select
  always_comb begin
    case (state_r)
      drrip_pkg::S_IDLE:    rd_addr = in_tdata[SW-1:0];
      drrip_pkg::S_HB_RD:   rd_addr = idx_r;
      default:              rd_addr = set_r;
    endcase
  end

  // memories: registered read, one write port each
  always_ff @(posedge clk) begin
    rrpv_q <= rrpv_mem[rd_addr];
    set_q  <= set_mem[rd_addr];
    if (rrpv_we) rrpv_mem[wr_addr] <= rrpv_wd;
    if (set_we)  set_mem[wr_addr]  <= set_wd;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      drrip_pkg::S_CLR:
        if (idx_r == SW'(drrip_pkg::NUM_SETS - 1)) state_nxt = drrip_pkg::S_IDLE;
      drrip_pkg::S_IDLE:
        if (in_xfer) begin
          case (in_tuser[1:0])
            drrip_pkg::CMD_UPDATE: state_nxt = drrip_pkg::S_U1;
            drrip_pkg::CMD_BEAT:   state_nxt = drrip_pkg::S_HB_RD;
            default:               state_nxt = drrip_pkg::S_LOOK;
          endcase
        end
      drrip_pkg::S_LOOK:
        if (cmd_r == drrip_pkg::CMD_VICTIM && !age_res.inv_any)
          state_nxt = drrip_pkg::S_AGE;
        else
          state_nxt = drrip_pkg::S_DONE;
      drrip_pkg::S_AGE:
        if (age_res.max_any) state_nxt = drrip_pkg::S_DONE;
      drrip_pkg::S_U1:      state_nxt = drrip_pkg::S_U2;
      drrip_pkg::S_U2:      state_nxt = drrip_pkg::S_DONE;
      drrip_pkg::S_HB_RD:   state_nxt = drrip_pkg::S_HB_WR;
      drrip_pkg::S_HB_WR:
        if (idx_r == SW'(drrip_pkg::NUM_SETS - 1)) state_nxt = drrip_pkg::S_HB_LAST;
        else state_nxt = drrip_pkg::S_HB_RD;
      drrip_pkg::S_HB_LAST: state_nxt = drrip_pkg::S_LOOK;
      drrip_pkg::S_DONE:
        if (out_load) state_nxt = drrip_pkg::S_IDLE;
      default:              state_nxt = drrip_pkg::S_CLR;
    endcase
  end

  // datapath and memory writes
  always_comb begin
    logic [drrip_pkg::CNT_W-1:0] cnt_new;
    logic [1:0]                  cur_rrpv;
    logic [1:0]                  ins;
    logic [drrip_pkg::LFSR_W-1:0] lfsr_adv;
    logic                        bim_near;
    idx_nxt    = idx_r;
    row_nxt    = row_r;
    rec_nxt    = rec_r;
    stride_nxt = stride_r;
    psel_nxt   = psel_r;
    lfsr_nxt   = lfsr_r;
    vic_nxt    = vic_r;
    strm_nxt   = strm_r;
    rrpv_we    = 1'b0;
    set_we     = 1'b0;
    wr_addr    = set_r;
    rrpv_wd    = row_r;
    set_wd     = rec_r;
    cnt_new    = rec_r.cnt;
    cur_rrpv   = row_r[way_r];
    ins        = drrip_pkg::RRPV_NEAR;
    lfsr_adv   = drrip_pkg::lfsr_step(lfsr_r);
    bim_near   = (lfsr_adv[4:0] == 5'd0);
    case (state_r)
      drrip_pkg::S_CLR: begin
        rrpv_we = 1'b1;
        set_we  = 1'b1;
        wr_addr = idx_r;
        for (int w = 0; w < drrip_pkg::NUM_WAYS; w++) rrpv_wd[w] = drrip_pkg::RRPV_MAX;
        set_wd  = '0;
        idx_nxt = idx_r + SW'(1);
      end
      drrip_pkg::S_IDLE: begin
        idx_nxt = '0;
        vic_nxt = '0;
      end
      drrip_pkg::S_LOOK: begin
        strm_nxt = (set_q.cnt >= thr_r);
        row_nxt  = rrpv_q;
        // the unit sees vmask_r directly; invalid way wins without a row read
        if (cmd_r == drrip_pkg::CMD_VICTIM && age_res.inv_any)
          vic_nxt = age_res.inv_way;
      end
      drrip_pkg::S_AGE: begin
        // age by one until some way reaches max, then write the row back
        if (age_res.max_any) begin
          vic_nxt = age_res.max_way;
          rrpv_we = 1'b1;
        end else begin
          row_nxt = age_res.aged;
        end
      end
      drrip_pkg::S_U1: begin
        rec_nxt    = set_q;
        row_nxt    = rrpv_q;
        stride_nxt = addr_r - set_q.prev_addr;
      end
      drrip_pkg::S_U2: begin
        // streaming counter
        if (rec_r.prev_addr != '0 && stride_r == rec_r.prev_stride) begin
          if (rec_r.cnt != drrip_pkg::CNT_TOP) cnt_new = rec_r.cnt + 2'd1;
        end else if (rec_r.cnt != '0) begin
          cnt_new = rec_r.cnt - 2'd1;
        end
        set_we = 1'b1;
        set_wd = '{prev_addr: addr_r, prev_stride: stride_r, cnt: cnt_new};
        strm_nxt = (cnt_new >= thr_r);
        // insertion policy and set dueling
        if (set_r < SW'(drrip_pkg::LEADERS)) begin
          ins = drrip_pkg::RRPV_NEAR;
          if (!hit_r && cur_rrpv == drrip_pkg::RRPV_MAX && psel_r != '0)
            psel_nxt = psel_r - 10'd1;
        end else if (set_r < SW'(2 * drrip_pkg::LEADERS)) begin
          ins = bim_near ? drrip_pkg::RRPV_NEAR : drrip_pkg::RRPV_MAX;
          if (!hit_r) begin
            lfsr_nxt = lfsr_adv;
            if (cur_rrpv == 2'd0 && psel_r != drrip_pkg::PSEL_TOP) psel_nxt = psel_r + 10'd1;
          end
        end else if (psel_r >= drrip_pkg::PSEL_MID) begin
          ins = drrip_pkg::RRPV_NEAR;
        end else begin
          ins = bim_near ? drrip_pkg::RRPV_NEAR : drrip_pkg::RRPV_MAX;
          if (!hit_r) lfsr_nxt = lfsr_adv;
        end
        if (cnt_new >= thr_r) ins = drrip_pkg::RRPV_MAX;
        if (hit_r) ins = 2'd0;
        rrpv_we = 1'b1;
        rrpv_wd[way_r] = ins;
      end
      drrip_pkg::S_HB_WR: begin
        // decay one set's counter
        set_we  = 1'b1;
        wr_addr = idx_r;
        set_wd  = set_q;
        if (set_q.cnt != '0) set_wd.cnt = set_q.cnt - 2'd1;
        idx_nxt = idx_r + SW'(1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drrip_pkg::S_CLR;
      idx_r       <= '0;
      psel_r      <= drrip_pkg::PSEL_MID;
      lfsr_r      <= drrip_pkg::LFSR_INIT;
      thr_r       <= drrip_pkg::THR_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      psel_r  <= psel_nxt;
      lfsr_r  <= lfsr_nxt;
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r   <= in_tuser[1:0];
      hit_r   <= in_tuser[2];
      set_r   <= in_tdata[10:0];
      way_r   <= in_tdata[14:11];
      addr_r  <= in_tdata[78:15];
      vmask_r <= in_tdata[94:79];
    end
    row_r    <= row_nxt;
    rec_r    <= rec_nxt;
    stride_r <= stride_nxt;
    vic_r    <= vic_nxt;
    strm_r   <= strm_nxt;
    if (out_load) begin
      out_vic_r  <= vic_r;
      out_psel_r <= psel_r;
      out_strm_r <= strm_r;
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("block ready right after accepting an item");

  a_psel_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != drrip_pkg::S_U2) |=> psel_r == $past(psel_r))
    else $error("selector moved outside the update step");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == drrip_pkg::S_DONE))
    else $error("result appeared without a finished item");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] CMD_NONE = 2'd3;  // unused code, block answers it without changing any state

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;  // set_index, way_index, phys_addr, valid_mask, zero pad
  logic [2:0]  in_tuser = '0;  // cmd, is_hit
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;      // victim_way, psel_value, zero pad
  logic        out_tuser;      // set_streaming

  typedef struct packed {
    logic [drrip_pkg::WAY_W-1:0]  victim;
    logic [drrip_pkg::PSEL_W-1:0] psel;
    logic                         streaming;
  } verdict_t;

  // predicted replacement state
  logic [1:0]                   rrpv_mem [drrip_pkg::NUM_SETS][drrip_pkg::NUM_WAYS];
  logic [drrip_pkg::ADDR_W-1:0] prev_addr_q [drrip_pkg::NUM_SETS];
  logic [drrip_pkg::ADDR_W-1:0] last_stride [drrip_pkg::NUM_SETS];
  logic [drrip_pkg::CNT_W-1:0]  stream_cnt [drrip_pkg::NUM_SETS];
  logic [drrip_pkg::PSEL_W-1:0] psel_q;
  logic [drrip_pkg::LFSR_W-1:0] lfsr_q;
  logic [1:0]                   threshold_q;

  verdict_t pending_verdicts[$];
  int  errors = 0;
  bit  quiet = 1'b0;       // no idling on either side
  bit  long_hold = 1'b0;   // receiver holds off for a long stretch
  int  hold_cnt = 0;

  drrip_streaming_replacement u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  // next insertion value from the bimodal LFSR
  function automatic logic [1:0] bimodal_rrpv();
    logic [drrip_pkg::LFSR_W-1:0] n;
    n = lfsr_q >> 1;
    if (lfsr_q[0]) n = n ^ drrip_pkg::LFSR_TAPS;
    lfsr_q = n;
    return (n[4:0] == 5'd0) ? drrip_pkg::RRPV_NEAR : drrip_pkg::RRPV_MAX;
  endfunction

  // advance the policy state by one item, return the result it produces
  function automatic verdict_t policy_step(logic [1:0] cmd, int s, int w,
                                           logic [63:0] addr, bit hit,
                                           logic [15:0] mask);
    verdict_t v;
    logic [63:0] stride;
    logic [1:0] top, ins;
    bit found;
    v = '0;
    if (cmd == drrip_pkg::CMD_VICTIM) begin
      found = 0;
      for (int i = 0; i < drrip_pkg::NUM_WAYS; i++)
        if (!found && !mask[i]) begin
          v.victim = drrip_pkg::WAY_W'(i); found = 1;
        end
      if (!found) begin
        top = 0;
        for (int i = 0; i < drrip_pkg::NUM_WAYS; i++)
          if (rrpv_mem[s][i] > top) top = rrpv_mem[s][i];
        for (int i = 0; i < drrip_pkg::NUM_WAYS; i++)
          rrpv_mem[s][i] = rrpv_mem[s][i] + (drrip_pkg::RRPV_MAX - top);
        for (int i = drrip_pkg::NUM_WAYS - 1; i >= 0; i--)
          if (rrpv_mem[s][i] == drrip_pkg::RRPV_MAX) v.victim = drrip_pkg::WAY_W'(i);
      end
    end else if (cmd == drrip_pkg::CMD_UPDATE) begin
      // stride streaming detector
      stride = addr - prev_addr_q[s];
      if (prev_addr_q[s] != 0 && stride == last_stride[s]) begin
        if (stream_cnt[s] < drrip_pkg::CNT_TOP) stream_cnt[s]++;
      end else if (stream_cnt[s] > 0) begin
        stream_cnt[s]--;
      end
      last_stride[s] = stride;
      prev_addr_q[s] = addr;
      if (hit) begin
        rrpv_mem[s][w] = 2'd0;
      end else begin
        if (s < drrip_pkg::LEADERS) begin
          ins = drrip_pkg::RRPV_NEAR;
          if (rrpv_mem[s][w] == drrip_pkg::RRPV_MAX && psel_q > 0) psel_q--;
        end else if (s < 2 * drrip_pkg::LEADERS) begin
          ins = bimodal_rrpv();
          if (rrpv_mem[s][w] == 2'd0 && psel_q < drrip_pkg::PSEL_TOP) psel_q++;
        end else if (psel_q >= drrip_pkg::PSEL_MID) begin
          ins = drrip_pkg::RRPV_NEAR;
        end else begin
          ins = bimodal_rrpv();
        end
        if (stream_cnt[s] >= threshold_q) ins = drrip_pkg::RRPV_MAX;
        rrpv_mem[s][w] = ins;
      end
    end else if (cmd == drrip_pkg::CMD_BEAT) begin
      for (int i = 0; i < drrip_pkg::NUM_SETS; i++)
        if (stream_cnt[i] > 0) stream_cnt[i]--;
    end
    v.psel = psel_q;
    v.streaming = stream_cnt[s] >= threshold_q;
    return v;
  endfunction

  // one transfer on the input side, then a random gap unless quiet
  task automatic send_item(logic [1:0] cmd, int s, int w, logic [63:0] addr,
                           bit hit, logic [15:0] mask);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, mask, addr, w[3:0], s[10:0]};
    in_tuser  <= {hit, cmd};
    do @(posedge clk); while (!in_tready);
    pending_verdicts.push_back(policy_step(cmd, s, w, addr, hit, mask));
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_threshold(logic [1:0] t);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    threshold_q = t;
  endtask

  // receiver: a random wait after each transfer unless quiet, or a long hold when asked
  always @(posedge clk) begin
    int rx_gap;
    if (long_hold) begin
      hold_cnt <= 400;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= (hold_cnt == 1);
    end else if (out_tvalid && out_tready && !quiet) begin
      rx_gap = $urandom_range(0, 14);
      hold_cnt <= rx_gap;
      out_tready <= (rx_gap == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result check
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result victim=%0d psel=%0d stream=%0b", $time,
                 out_tdata[3:0], out_tdata[13:4], out_tuser);
        errors++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (out_tdata[3:0] !== exp_v.victim) begin
          $display("%0t: victim_way expected %0d actual %0d", $time, exp_v.victim,
                   out_tdata[3:0]);
          errors++;
        end
        if (out_tdata[13:4] !== exp_v.psel) begin
          $display("%0t: psel_value expected %0d actual %0d", $time, exp_v.psel,
                   out_tdata[13:4]);
          errors++;
        end
        if (out_tuser !== exp_v.streaming) begin
          $display("%0t: set_streaming expected %0b actual %0b", $time,
                   exp_v.streaming, out_tuser);
          errors++;
        end
      end
    end
  end

  // one random item, mostly on a small pool of sets so state builds up
  task automatic random_item();
    int s, pick, w;
    logic [63:0] addr;
    logic [15:0] mask;
    logic [1:0] cmd;
    pick = $urandom_range(0, 9);
    if (pick < 3)      s = $urandom_range(0, 3);
    else if (pick < 6) s = $urandom_range(64, 67);
    else if (pick < 9) s = $urandom_range(300, 303);
    else               s = $urandom_range(0, drrip_pkg::NUM_SETS - 1);
    w = $urandom_range(0, drrip_pkg::NUM_WAYS - 1);
    pick = $urandom_range(0, 199);
    if (pick < 2)       cmd = drrip_pkg::CMD_BEAT;
    else if (pick < 4)  cmd = CMD_NONE;
    else if (pick < 70) cmd = drrip_pkg::CMD_VICTIM;
    else                cmd = drrip_pkg::CMD_UPDATE;
    mask = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hFFFF;
    // strided address sequences with the odd random jump
    if ($urandom_range(0, 4) == 0)
      addr = {$urandom, $urandom};
    else
      addr = prev_addr_q[s] + (last_stride[s] == 0 ? 64'd64 : last_stride[s]);
    send_item(cmd, s, w, addr, $urandom_range(0, 2) == 0, mask);
  endtask

  task automatic test_directed();
    send_item(drrip_pkg::CMD_VICTIM, 0, 0, 0, 0, 16'h0000);
    send_item(drrip_pkg::CMD_VICTIM, 2047, 0, 0, 0, 16'h7FFF);
    send_item(drrip_pkg::CMD_VICTIM, 5, 0, 0, 0, 16'hFFFF);
    // hits then victim search that must age the set
    for (int i = 0; i < 16; i++)
      send_item(drrip_pkg::CMD_UPDATE, 200, i, 64'h1000 + i, 1, 0);
    send_item(drrip_pkg::CMD_VICTIM, 200, 0, 0, 0, 16'hFFFF);
    // leader fills steer the selector both ways
    send_item(drrip_pkg::CMD_UPDATE, 0, 3, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    send_item(drrip_pkg::CMD_UPDATE, 64, 7, 64'h40, 1, 0);
    send_item(drrip_pkg::CMD_UPDATE, 64, 7, 64'h80, 0, 0);
    send_item(drrip_pkg::CMD_UPDATE, 1000, 15, 64'hC0, 0, 16'hFFFF);
    // constant stride builds a stream
    for (int i = 1; i <= 5; i++)
      send_item(drrip_pkg::CMD_UPDATE, 400, 2, 64'h100 * i, 0, 0);
    send_item(drrip_pkg::CMD_BEAT, 400, 0, 0, 0, 0);
    send_item(CMD_NONE, 400, 0, 0, 1, 16'hFFFF);
  endtask

  task automatic test_threshold();
    logic [1:0] levels[4] = '{2'd0, 2'd3, 2'd1, 2'd2};
    foreach (levels[k]) begin
      write_threshold(levels[k]);
      for (int i = 0; i < 100; i++) random_item();
    end
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      quiet = ((i / 60) % 4 == 3);
      random_item();
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    wait_idle();
    quiet = 1'b1;
    long_hold <= 1'b1;
    @(posedge clk);
    long_hold <= 1'b0;
    for (int i = 0; i < 30; i++) random_item();
    quiet = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    threshold_q = drrip_pkg::THR_INIT;
    psel_q = drrip_pkg::PSEL_MID;
    lfsr_q = drrip_pkg::LFSR_INIT;
    for (int i = 0; i < drrip_pkg::NUM_SETS; i++) begin
      prev_addr_q[i] = '0;
      last_stride[i] = '0;
      stream_cnt[i] = '0;
      for (int j = 0; j < drrip_pkg::NUM_WAYS; j++) rrpv_mem[i][j] = drrip_pkg::RRPV_MAX;
    end
    test_directed();
    test_threshold();
    test_backpressure();
    test_random(300);
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/drrip_pkg.sv
rtl/drrip_age_unit.sv
rtl/drrip_streaming_replacement.sv
test/tb.sv
